// File: rtl/hll_pkg.sv
// Shared constants, types and helper functions for the HyperLogLog register update block.
`timescale 1ns / 1ps

package hll_pkg;

  localparam int INDEX_BITS        = 14;
  localparam int SUM_FRACTION_BITS = 48;
  localparam int REG_COUNT         = 1 << INDEX_BITS;

  localparam int ITEM_W  = 64;
  localparam int INDEX_W = 14;
  localparam int RANK_W  = 7;
  localparam int SUM_W   = 63;
  localparam int ZERO_W  = 15;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SHIFT = 33;

  localparam logic [63:0]       SUM_INIT_FULL = 64'(REG_COUNT) << SUM_FRACTION_BITS;
  localparam logic [SUM_W-1:0]  SUM_INIT      = SUM_INIT_FULL[SUM_W-1:0];
  localparam logic [ZERO_W-1:0] ZERO_INIT     = ZERO_W'(REG_COUNT);
  localparam logic [RANK_W-1:0] RANK_MAX      = RANK_W'(65);

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [RANK_W-1:0]     rank_t;
  typedef logic [SUM_W-1:0]      sum_t;

  // xor-fold used before, between and after the multiplies of the finalizer
  function automatic logic [63:0] xor_fold(input logic [63:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

  // leading zeros of one byte, valid when the byte is nonzero
  function automatic logic [2:0] lz8(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 3'(7 - i);
    end
    return n;
  endfunction

  // 2^-rank in fixed point, truncated below the last fraction bit
  function automatic sum_t weight(input rank_t r);
    if (r > RANK_W'(SUM_FRACTION_BITS)) return '0;
    return SUM_W'(1) << (RANK_W'(SUM_FRACTION_BITS) - r);
  endfunction

endpackage

// File: rtl/hll_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module hll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/hyperloglog_register_update.sv
// Top level of the HyperLogLog register update block.
// After reset the block sweeps the rank RAM to zero, one entry a cycle, over all 2^INDEX_BITS
// entries (16384 by default) and holds in_stall high meanwhile. Each accepted item then
// passes through these steps before its result is registered at the output: a shared bank
// of 32x32 multipliers runs the hash finalizer in two multiply/fold pairs, a two-step
// leading-zero scan finds the rank while the rank RAM is read, and a final step updates the
// harmonic sum, the zero-register count and the RAM. One item is in flight at a time; a new
// item is taken while the previous result waits in the output register, and a stalled
// result holds the next one in the update step.
`timescale 1ns / 1ps

module hyperloglog_register_update
  import hll_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ITEM_W-1:0]  in_item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [INDEX_W-1:0] out_register_index,
  output logic [RANK_W-1:0]  out_item_rank,
  output logic               out_register_raised,
  output logic [SUM_W-1:0]   out_harmonic_sum,
  output logic [ZERO_W-1:0]  out_zero_registers
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MIX1, ST_FOLD1, ST_MIX2, ST_FOLD2, ST_SCAN, ST_RANK, ST_DELTA, ST_UPD
  } state_t;

  state_t            state_r;
  idx_t              clr_r;
  logic [63:0]       v_r;
  logic [63:0]       pl_r;
  logic [31:0]       ph_r;
  logic [31:0]       pm_r;
  logic [7:0]        grp_nz_r;
  logic [2:0]        grp_lz_r [8];
  rank_t             rank_r;
  rank_t             old_r;
  logic              raised_r;
  logic              old_zero_r;
  sum_t              delta_r;
  sum_t              sum_r;
  logic [ZERO_W-1:0] zero_r;
  logic              out_valid_r;

  logic [63:0]       mul_c;
  logic [63:0]       prod_ll;
  logic [31:0]       prod_hl;
  logic [31:0]       prod_lh;
  logic [63:0]       folded;
  logic [63:0]       w;
  logic [63:0]       idx_ext;
  idx_t              idx;
  rank_t             lz;
  rank_t             rank_new;
  sum_t              sum_nxt;
  logic [ZERO_W-1:0] zero_nxt;
  logic              upd_fire;
  logic              ram_we;
  idx_t              ram_waddr;
  rank_t             ram_wdata;
  rank_t             ram_rdata;

  assign mul_c   = (state_r == ST_MIX1) ? MIX_C1 : MIX_C2;
  assign prod_ll = 64'(v_r[31:0]) * 64'(mul_c[31:0]);
  assign prod_hl = v_r[63:32] * mul_c[31:0];
  assign prod_lh = v_r[31:0] * mul_c[63:32];
  assign folded  = xor_fold(pl_r + {ph_r + pm_r, 32'b0});

  assign idx     = v_r[63 -: INDEX_BITS];
  assign idx_ext = 64'(idx);
  assign w       = v_r << INDEX_BITS;

  always_comb begin
    lz = RANK_W'(64);
    for (int g = 0; g < 8; g++) begin
      if (grp_nz_r[g]) lz = RANK_W'((7 - g) * 8) + RANK_W'(grp_lz_r[g]);
    end
    rank_new = lz + RANK_W'(1);
  end

  assign upd_fire = (state_r == ST_UPD) && (!out_valid_r || !out_stall);
  assign sum_nxt  = raised_r ? sum_r - delta_r : sum_r;
  assign zero_nxt = (raised_r && old_zero_r) ? zero_r - ZERO_W'(1) : zero_r;

  assign ram_we    = (state_r == ST_CLEAR) || (upd_fire && raised_r);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_r : idx;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : rank_r;

  hll_ram #(
    .WIDTH (RANK_W),
    .DEPTH (REG_COUNT)
  ) u_rank_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (state_r == ST_SCAN),
    .rd_addr (idx),
    .rd_data (ram_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      sum_r       <= SUM_INIT;
      zero_r      <= ZERO_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !upd_fire) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + idx_t'(1);
          if (clr_r == '1) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) begin
            v_r     <= xor_fold(in_item_value);
            state_r <= ST_MIX1;
          end
        end
        ST_MIX1, ST_MIX2: begin
          pl_r    <= prod_ll;
          ph_r    <= prod_hl;
          pm_r    <= prod_lh;
          state_r <= (state_r == ST_MIX1) ? ST_FOLD1 : ST_FOLD2;
        end
        ST_FOLD1, ST_FOLD2: begin
          v_r     <= folded;
          state_r <= (state_r == ST_FOLD1) ? ST_MIX2 : ST_SCAN;
        end
        ST_SCAN: begin
          for (int g = 0; g < 8; g++) begin
            grp_nz_r[g] <= |w[8*g +: 8];
            grp_lz_r[g] <= lz8(w[8*g +: 8]);
          end
          state_r <= ST_RANK;
        end
        ST_RANK: begin
          rank_r  <= rank_new;
          old_r   <= ram_rdata;
          state_r <= ST_DELTA;
        end
        ST_DELTA: begin
          raised_r   <= rank_r > old_r;
          old_zero_r <= (old_r == '0);
          delta_r    <= weight(old_r) - weight(rank_r);
          state_r    <= ST_UPD;
        end
        ST_UPD: begin
          if (upd_fire) begin
            sum_r               <= sum_nxt;
            zero_r              <= zero_nxt;
            out_valid_r         <= 1'b1;
            out_register_index  <= idx_ext[INDEX_W-1:0];
            out_item_rank       <= rank_r;
            out_register_raised <= raised_r;
            out_harmonic_sum    <= sum_nxt;
            out_zero_registers  <= zero_nxt;
            state_r             <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_MIX1)
    else $error("accepted transaction did not start the hash");

  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_UPD))
    else $error("result appeared outside the update step");

  a_ram_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && state_r != ST_CLEAR |-> state_r == ST_UPD && raised_r)
    else $error("rank RAM written without a raise");

  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DELTA |-> rank_r >= RANK_W'(1) && rank_r <= RANK_MAX)
    else $error("rank out of range");

endmodule

// File: dv/hyperloglog_register_update_tb.sv
// Self-checking testbench for the HyperLogLog register update block.
`timescale 1ns / 1ps

module hyperloglog_register_update_tb;
  import hll_pkg::*;

  typedef struct {
    logic [INDEX_W-1:0] register_index;
    logic [RANK_W-1:0]  item_rank;
    logic               register_raised;
    logic [SUM_W-1:0]   harmonic_sum;
    logic [ZERO_W-1:0]  zero_registers;
  } reg_update_t;

  localparam int LONG_HOLD = 400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ITEM_W-1:0]  in_item_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [INDEX_W-1:0] out_register_index;
  logic [RANK_W-1:0]  out_item_rank;
  logic               out_register_raised;
  logic [SUM_W-1:0]   out_harmonic_sum;
  logic [ZERO_W-1:0]  out_zero_registers;

  // predicted register file, harmonic sum and zero count
  logic [RANK_W-1:0]  model_ranks [REG_COUNT];
  logic [SUM_W-1:0]   model_sum;
  logic [ZERO_W-1:0]  model_zeros;

  reg_update_t pending_updates [$];
  reg_update_t got_update;
  int          error_count = 0;
  int          burst_left = 20;
  bit          sending = 1'b0;
  bit          hold_request = 1'b0;
  logic [63:0] inv_c1;
  logic [63:0] inv_c2;

  hyperloglog_register_update dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_item_value       (in_item_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_register_index  (out_register_index),
    .out_item_rank       (out_item_rank),
    .out_register_raised (out_register_raised),
    .out_harmonic_sum    (out_harmonic_sum),
    .out_zero_registers  (out_zero_registers)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [63:0] mix_hash(input logic [63:0] v);
    logic [63:0] x;
    x = v ^ (v >> 33);
    x = x * MIX_C1;
    x = x ^ (x >> 33);
    x = x * MIX_C2;
    x = x ^ (x >> 33);
    return x;
  endfunction

  // inverse of an odd constant modulo 2^64 by Newton iteration
  function automatic logic [63:0] odd_inverse(input logic [63:0] c);
    logic [63:0] x;
    x = c;
    for (int i = 0; i < 6; i++) x = x * (64'd2 - c * x);
    return x;
  endfunction

  function automatic logic [63:0] unmix_hash(input logic [63:0] h);
    logic [63:0] x;
    x = h ^ (h >> 33);
    x = x * inv_c2;
    x = x ^ (x >> 33);
    x = x * inv_c1;
    x = x ^ (x >> 33);
    return x;
  endfunction

  function automatic logic [SUM_W-1:0] rank_weight(input logic [RANK_W-1:0] r);
    if (r > SUM_FRACTION_BITS) return '0;
    return SUM_W'(1) << (SUM_FRACTION_BITS - r);
  endfunction

  function automatic reg_update_t predict_update(input logic [ITEM_W-1:0] value);
    reg_update_t u;
    logic [63:0] h;
    logic [63:0] w;
    logic [RANK_W-1:0] r;
    logic [INDEX_W-1:0] idx;
    logic [RANK_W-1:0] prev;
    h = mix_hash(value);
    idx = h[63 -: INDEX_BITS];
    w = h << INDEX_BITS;
    r = 7'd1;
    for (int b = 63; b >= 0; b--) begin
      if (w[b]) break;
      r++;
    end
    prev = model_ranks[idx];
    u.register_raised = (r > prev);
    if (u.register_raised) begin
      model_sum = model_sum - rank_weight(prev) + rank_weight(r);
      if (prev == 0) model_zeros = model_zeros - 1'b1;
      model_ranks[idx] = r;
    end
    u.register_index = idx;
    u.item_rank = r;
    u.harmonic_sum = model_sum;
    u.zero_registers = model_zeros;
    return u;
  endfunction

  // item whose hash lands on register idx with the given rank (1..50, or 65)
  function automatic logic [ITEM_W-1:0] item_for(input int idx, input int r);
    logic [63:0] h;
    logic [49:0] rem;
    rem = 50'({$urandom, $urandom});
    if (r == 65) rem = '0;
    else rem = (rem & ((50'd1 << (50 - r)) - 1'b1)) | (50'd1 << (50 - r));
    h = {idx[13:0], rem};
    return unmix_hash(h);
  endfunction

  function automatic logic [ITEM_W-1:0] random_item();
    int idx;
    int r;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return {$urandom, $urandom};
    idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, REG_COUNT - 1);
    case ($urandom_range(0, 7))
      0:       r = 65;
      1, 2:    r = $urandom_range(40, 50);
      default: r = $urandom_range(1, 12);
    endcase
    return item_for(idx, r);
  endfunction

  task automatic send_item(input logic [ITEM_W-1:0] value);
    in_valid <= 1'b1;
    in_item_value <= value;
    sending = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_updates.push_back(predict_update(value));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      sending = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
    end
  endtask

  task automatic stop_sending();
    if (sending) begin
      in_valid <= 1'b0;
      sending = 1'b0;
    end
  endtask

  task automatic wait_for_results();
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  task automatic test_value_extremes();
    send_item('0);
    send_item('1);
    send_item(64'd1);
    send_item(64'h8000_0000_0000_0000);
    send_item(64'h5555_5555_5555_5555);
    send_item(64'haaaa_aaaa_aaaa_aaaa);
  endtask

  task automatic test_rank_boundaries();
    send_item(item_for(0, 1));
    send_item(item_for(REG_COUNT - 1, 65));  // all-zero remainder
    send_item(item_for(REG_COUNT - 1, 2));   // lower rank, no raise
    send_item(item_for(5, 47));
    send_item(item_for(5, 48));
    send_item(item_for(5, 49));              // weight truncated to zero
    send_item(item_for(5, 50));
    send_item(item_for(5, 3));
    send_item(item_for(5, 50));              // equal rank, no raise
    send_item(item_for(7, 49));
    send_item(item_for(8, 48));
    send_item(item_for(8, 65));
    send_item(item_for(9, 1));
    send_item(item_for(9, 1));
  endtask

  task automatic test_long_hold();
    hold_request = 1'b1;
    repeat (25) send_item(random_item());
  endtask

  task automatic test_drain_pause();
    repeat (10) send_item(random_item());
    stop_sending();
    wait_for_results();
    repeat (10) send_item(random_item());
  endtask

  task automatic test_random_stream();
    repeat (680) send_item(random_item());
  endtask

  initial begin : receiver
    int phase_left;
    int stall_pct;
    phase_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
        hold_request = 1'b0;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(1, 60);
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          default: stall_pct = 75;
        endcase
      end
      phase_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_updates.size() == 0) begin
        $error("result transaction with nothing expected, index %0d", out_register_index);
        error_count++;
      end else begin
        got_update = pending_updates.pop_front();
        if (out_register_index !== got_update.register_index) begin
          $error("register_index expected %0d actual %0d",
                 got_update.register_index, out_register_index);
          error_count++;
        end
        if (out_item_rank !== got_update.item_rank) begin
          $error("item_rank expected %0d actual %0d", got_update.item_rank, out_item_rank);
          error_count++;
        end
        if (out_register_raised !== got_update.register_raised) begin
          $error("register_raised expected %0d actual %0d",
                 got_update.register_raised, out_register_raised);
          error_count++;
        end
        if (out_harmonic_sum !== got_update.harmonic_sum) begin
          $error("harmonic_sum expected %h actual %h",
                 got_update.harmonic_sum, out_harmonic_sum);
          error_count++;
        end
        if (out_zero_registers !== got_update.zero_registers) begin
          $error("zero_registers expected %0d actual %0d",
                 got_update.zero_registers, out_zero_registers);
          error_count++;
        end
      end
    end
  end

  initial begin
    inv_c1 = odd_inverse(MIX_C1);
    inv_c2 = odd_inverse(MIX_C2);
    for (int i = 0; i < REG_COUNT; i++) model_ranks[i] = '0;
    model_sum = SUM_W'(REG_COUNT) << SUM_FRACTION_BITS;
    model_zeros = ZERO_W'(REG_COUNT);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_value_extremes();
    test_rank_boundaries();
    test_long_hold();
    test_drain_pause();
    test_random_stream();
    stop_sending();
    wait_for_results();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_updates.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/hll_pkg.sv
rtl/hll_ram.sv
rtl/hyperloglog_register_update.sv
dv/hyperloglog_register_update_tb.sv
